[rtl/pxsc_pkg.sv]
// ----------------------------------------------------------------------------
// pxsc_pkg
// Shared types and codes of the polyline slab chopper.
// ----------------------------------------------------------------------------
package pxsc_pkg;

   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_LINE = 1'b1;

   localparam logic [1:0] REG_CHOP_ENABLE = 2'd0;
   localparam logic [1:0] REG_CLOSE_CHOPS = 2'd1;
   localparam logic [1:0] REG_SLAB_START  = 2'd2;
   localparam logic [1:0] REG_SLAB_END    = 2'd3;

   // boundary select for interpolation target
   localparam logic [1:0] XC_CROSS = 2'd0;
   localparam logic [1:0] XC_START = 2'd1;
   localparam logic [1:0] XC_END   = 2'd2;

   // line origin select
   localparam logic ORG_OUTSIDE = 1'b0;
   localparam logic ORG_LAST    = 1'b1;

   // y select for an emitted result
   localparam logic [1:0] YS_INTERP = 2'd0;
   localparam logic [1:0] YS_POINT  = 2'd1;

   typedef struct packed {
      logic       load;       // capture input item
      logic       interp_go;  // start interpolation
      logic       org;        // origin of the line
      logic [1:0] xc_sel;     // boundary target
      logic       emit;       // load result register
      logic       emit_cmd;
      logic [1:0] emit_xsel;  // XC_* or point when XC_END+1
      logic       emit_ypt;   // 1 use point y
      logic       emit_last;
      logic       upd_out;    // outside point <= input
      logic       upd_cross;  // crossing_x <= target boundary
      logic [1:0] cross_sel;
   } pxsc_cmd_type;

   typedef struct packed {
      logic op;
      logic left;
      logic outside;
      logic oflag;      // an outside point is pending
      logic out_left;   // stored outside point is left of slab
      logic out_right;
      logic x_eq_cross;
      logic near_eq_cross;
      logic interp_done;
      logic rsp_busy;
   } pxsc_stat_type;

   localparam logic [1:0] XS_POINT = 2'd3;

endpackage

[rtl/pxsc_divider.sv]
// ----------------------------------------------------------------------------
// pxsc_divider
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pxsc_divider
   import pxsc_pkg::*;
#(
   parameter int NUM_WIDTH = 64,
   parameter int DEN_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numer,
   input  logic [DEN_WIDTH-1:0] denom,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quot
);
   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [NUM_WIDTH-1:0] q_ff, q_in;
   logic [DEN_WIDTH:0]   rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_WIDTH:0]   trial;

   always_comb begin
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_WIDTH-1:0], num_ff[NUM_WIDTH-1]};
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CW'(NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

[rtl/pxsc_datapath.sv]
// ----------------------------------------------------------------------------
// pxsc_datapath
// Coordinate registers, slab compares, interpolation and result register.
// ----------------------------------------------------------------------------
module pxsc_datapath
   import pxsc_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pxsc_cmd_type           cmd,
   output pxsc_stat_type          stat,
   input  logic                   req_operation,
   input  logic [COORD_WIDTH-1:0] req_point_x,
   input  logic [COORD_WIDTH-1:0] req_point_y,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data,
   output logic                   chop_enable,
   output logic                   close_flag,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_command,
   output logic [COORD_WIDTH-1:0] rsp_out_x,
   output logic [COORD_WIDTH-1:0] rsp_out_y,
   output logic                   rsp_last_of_run
);
   localparam int CW = COORD_WIDTH;
   localparam int PW = 2 * CW + 2;
   localparam int HW = CW / 2 + 1;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   logic                 chop_ff, close_ff, crossed_ff;
   logic signed [CW-1:0] start_ff, end_ff;
   logic                 op_ff;
   logic signed [CW-1:0] px_ff, py_ff;
   logic signed [CW-1:0] ox_ff, oy_ff, cx_ff, lx_ff, ly_ff;
   logic                 oflag_ff, oflag_in;

   // interpolation sequencer
   localparam logic [2:0] I_IDLE = 3'd0, I_MUL0 = 3'd1, I_MUL1 = 3'd2,
                          I_MUL2 = 3'd3, I_MUL3 = 3'd4, I_DIV = 3'd5, I_SUM = 3'd6;
   logic [2:0]           ist_ff, ist_in;
   logic [CW:0]          my_ff, mc_ff, mx_ff;
   logic                 neg_ff, vert_ff;
   logic signed [CW-1:0] y0_ff;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [1:0]           pidx_ff;
   logic signed [CW-1:0] iy_ff, iy_in;
   logic                 idone_ff, idone_in;
   logic                 dstart;
   logic                 ddone;
   logic [PW-1:0]        dquot;

   logic signed [CW-1:0] ax, ay, xc;
   logic signed [CW:0]   dy, dc, dx;
   logic [HW-1:0]        pa, pb;
   logic [2*HW-1:0]      pp;
   logic [PW-1:0]        sh;
   logic signed [CW+1:0] sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         chop_ff  <= 1'b0;
         close_ff <= 1'b0;
         start_ff <= '0;
         end_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CHOP_ENABLE: chop_ff  <= csr_data[0];
            REG_CLOSE_CHOPS: close_ff <= csr_data[0];
            REG_SLAB_START:  start_ff <= CW'(signed'(csr_data));
            REG_SLAB_END:    end_ff   <= CW'(signed'(csr_data));
            default: ;
         endcase
      end
   end
   assign chop_enable = chop_ff;
   assign close_flag  = close_ff & crossed_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         px_ff <= req_point_x;
         py_ff <= req_point_y;
      end
   end

   function automatic logic signed [CW-1:0] bsel(input logic [1:0] s,
         input logic signed [CW-1:0] c, input logic signed [CW-1:0] a,
         input logic signed [CW-1:0] b, input logic signed [CW-1:0] p);
      case (s)
         XC_CROSS: bsel = c;
         XC_START: bsel = a;
         XC_END:   bsel = b;
         default:  bsel = p;
      endcase
   endfunction

   logic left, outside;
   assign left    = px_ff < start_ff;
   assign outside = left || (px_ff > end_ff);

   assign stat.op            = op_ff;
   assign stat.left          = left;
   assign stat.outside       = outside;
   assign stat.oflag         = oflag_ff;
   assign stat.out_left      = oflag_ff && (ox_ff < start_ff);
   assign stat.out_right     = oflag_ff && (ox_ff > end_ff);
   assign stat.x_eq_cross    = px_ff == cx_ff;
   assign stat.near_eq_cross = (left ? end_ff : start_ff) == cx_ff;
   assign stat.interp_done   = idone_ff;
   assign stat.rsp_busy      = rsp_valid && !rsp_ready;

   // state updates
   always_comb begin
      oflag_in = oflag_ff;
      if (cmd.upd_out) oflag_in = outside;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oflag_ff   <= 1'b0;
         crossed_ff <= 1'b0;
         ox_ff <= '0; oy_ff <= '0; cx_ff <= '0; lx_ff <= '0; ly_ff <= '0;
      end else begin
         oflag_ff <= oflag_in;
         if (cmd.upd_out && outside) begin
            ox_ff <= px_ff;
            oy_ff <= py_ff;
         end
         if (cmd.upd_cross) begin
            cx_ff <= bsel(cmd.cross_sel, cx_ff, start_ff, end_ff, px_ff);
            if (op_ff == OP_LINE) crossed_ff <= 1'b1;
         end
         if (cmd.emit) begin
            lx_ff <= bsel(cmd.emit_xsel, cx_ff, start_ff, end_ff, px_ff);
            ly_ff <= cmd.emit_ypt ? py_ff : iy_ff;
         end
      end
   end

   // interpolation: |dy|*|dc| by four half-width partial products, then divide
   assign ax = (cmd.org == ORG_LAST) ? lx_ff : ox_ff;
   assign ay = (cmd.org == ORG_LAST) ? ly_ff : oy_ff;
   assign xc = bsel(cmd.xc_sel, cx_ff, start_ff, end_ff, px_ff);
   assign dy = (CW+1)'(py_ff) - (CW+1)'(ay);
   assign dc = (CW+1)'(xc) - (CW+1)'(ax);
   assign dx = (CW+1)'(px_ff) - (CW+1)'(ax);

   always_comb begin
      pa = pidx_ff[0] ? HW'(my_ff >> HW) : my_ff[HW-1:0];
      pb = pidx_ff[1] ? HW'(mc_ff >> HW) : mc_ff[HW-1:0];
      pp = pa * pb;
      sh = PW'(pp) << (HW * (32'(pidx_ff[0]) + 32'(pidx_ff[1])));
   end

   assign sum = neg_ff ? (CW+2)'(y0_ff) - (CW+2)'(dquot)
                       : (CW+2)'(y0_ff) + (CW+2)'(dquot);
   assign dstart = (ist_ff == I_MUL3);

   always_comb begin
      ist_in   = ist_ff;
      prod_in  = prod_ff;
      iy_in    = iy_ff;
      idone_in = 1'b0;
      unique case (ist_ff)
         I_IDLE: if (cmd.interp_go) ist_in = I_MUL0;
         I_MUL0: begin prod_in = sh;           ist_in = I_MUL1; end
         I_MUL1: begin prod_in = prod_ff + sh; ist_in = I_MUL2; end
         I_MUL2: begin prod_in = prod_ff + sh; ist_in = I_MUL3; end
         I_MUL3: begin prod_in = prod_ff + sh; ist_in = I_DIV;  end
         I_DIV:  if (ddone) ist_in = I_SUM;
         I_SUM: begin
            // a quotient of 2^CW or more saturates, unless the line is vertical
            if (vert_ff) iy_in = y0_ff;
            else if (dquot[PW-1:CW] != '0) iy_in = neg_ff ? CMIN : CMAX;
            else if (sum > (CW+2)'(CMAX)) iy_in = CMAX;
            else if (sum < (CW+2)'(CMIN)) iy_in = CMIN;
            else iy_in = CW'(sum);
            idone_in = 1'b1;
            ist_in   = I_IDLE;
         end
         default: ist_in = I_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ist_ff   <= I_IDLE;
         idone_ff <= 1'b0;
         pidx_ff  <= '0;
      end else begin
         ist_ff   <= ist_in;
         idone_ff <= idone_in;
         if (ist_ff == I_IDLE) pidx_ff <= '0;
         else if (ist_ff != I_DIV && ist_ff != I_SUM) pidx_ff <= pidx_ff + 1'b1;
      end
      prod_ff <= prod_in;
      iy_ff   <= iy_in;
      if (ist_ff == I_IDLE && cmd.interp_go) begin
         my_ff   <= dy[CW] ? (CW+1)'(-dy) : dy;
         mc_ff   <= dc[CW] ? (CW+1)'(-dc) : dc;
         mx_ff   <= dx[CW] ? (CW+1)'(-dx) : dx;
         neg_ff  <= dy[CW] ^ dc[CW] ^ dx[CW];
         vert_ff <= dx == '0;
         y0_ff   <= ay;
      end
   end

   pxsc_divider #(.NUM_WIDTH(PW), .DEN_WIDTH(CW+1)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dstart),
      .numer (prod_in),
      .denom (mx_ff),
      .done  (ddone),
      .quot  (dquot)
   );

   // result register
   logic rv_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (cmd.emit) rv_ff <= 1'b1;
      else if (rsp_ready) rv_ff <= 1'b0;
      if (cmd.emit) begin
         rsp_command     <= cmd.emit_cmd;
         rsp_out_x       <= bsel(cmd.emit_xsel, cx_ff, start_ff, end_ff, px_ff);
         rsp_out_y       <= cmd.emit_ypt ? py_ff : iy_ff;
         rsp_last_of_run <= cmd.emit_last;
      end
   end
   assign rsp_valid = rv_ff;
endmodule

[rtl/pxsc_control.sv]
// ----------------------------------------------------------------------------
// pxsc_control
// Sequencer: decides the chopping case and steps emits and interpolations.
// ----------------------------------------------------------------------------
module pxsc_control
   import pxsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          chop_enable,
   input  logic          close_flag,
   input  pxsc_stat_type stat,
   output pxsc_cmd_type  cmd
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DECIDE = 4'd1, S_WAIT = 4'd2,
                          S_EMIT = 4'd3, S_DONE = 4'd4;

   // step codes
   localparam logic [2:0] K_PASS = 3'd0, K_EXIT = 3'd1, K_REENTRY = 3'd2,
                          K_REPT = 3'd3, K_J0 = 3'd4, K_J1 = 3'd5, K_J2 = 3'd6;

   logic [3:0] st_ff, st_in;
   logic [2:0] k_ff, k_in;
   logic       jump;
   logic [1:0] bx, nb;

   assign bx   = stat.left ? XC_START : XC_END;
   assign nb   = stat.left ? XC_END : XC_START;
   assign jump = (stat.out_left && !stat.left) || (stat.out_right && stat.left);

   always_comb begin
      st_in = st_ff;
      k_in  = k_ff;
      cmd   = '0;
      cmd.org       = ORG_OUTSIDE;
      cmd.xc_sel    = XC_CROSS;
      cmd.emit_xsel = XS_POINT;
      cmd.cross_sel = bx;
      req_ready = (st_ff == S_IDLE);
      unique case (st_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            st_in    = S_DECIDE;
         end
         S_DECIDE: begin
            if (!chop_enable || (stat.op == OP_MOVE && !stat.outside)
                || (stat.op == OP_LINE && !stat.outside && !stat.oflag)) begin
               k_in = K_PASS;
               st_in = S_EMIT;
               if (chop_enable) cmd.upd_out = 1'b1;
            end else if (stat.op == OP_MOVE) begin
               cmd.upd_out   = 1'b1;
               cmd.upd_cross = 1'b1;
               st_in = S_DONE;
            end else if (stat.outside && !stat.oflag) begin
               k_in = K_EXIT;
               cmd.interp_go = 1'b1;
               cmd.org = ORG_LAST;
               cmd.xc_sel = bx;
               st_in = S_WAIT;
            end else if (stat.outside && !jump) begin
               cmd.upd_out = 1'b1;
               st_in = S_DONE;
            end else if (stat.outside) begin
               k_in = K_J0;
               cmd.interp_go = 1'b1;
               st_in = S_WAIT;
            end else begin
               k_in = K_REENTRY;
               cmd.interp_go = 1'b1;
               st_in = S_WAIT;
            end
         end
         S_WAIT: if (stat.interp_done) st_in = S_EMIT;
         S_EMIT: if (!stat.rsp_busy) begin
            cmd.emit = 1'b1;
            unique case (k_ff)
               K_PASS: begin
                  cmd.emit_cmd  = chop_enable ? stat.op : stat.op;
                  cmd.emit_ypt  = 1'b1;
                  cmd.emit_last = 1'b1;
                  st_in = S_DONE;
               end
               K_EXIT: begin
                  cmd.emit_cmd  = OP_LINE;
                  cmd.emit_xsel = bx;
                  cmd.emit_last = 1'b1;
                  cmd.upd_out   = 1'b1;
                  cmd.upd_cross = 1'b1;
                  st_in = S_DONE;
               end
               K_REENTRY: begin
                  cmd.emit_cmd  = close_flag;
                  cmd.emit_xsel = XC_CROSS;
                  cmd.emit_last = stat.x_eq_cross;
                  cmd.upd_out   = stat.x_eq_cross;
                  if (stat.x_eq_cross) st_in = S_DONE;
                  else begin
                     k_in = K_REPT;
                     st_in = S_EMIT;
                  end
               end
               K_REPT: begin
                  cmd.emit_cmd  = OP_LINE;
                  cmd.emit_ypt  = 1'b1;
                  cmd.emit_last = 1'b1;
                  cmd.upd_out   = 1'b1;
                  st_in = S_DONE;
               end
               K_J0: begin
                  cmd.emit_cmd  = close_flag;
                  cmd.emit_xsel = XC_CROSS;
                  if (stat.near_eq_cross) begin
                     k_in = K_J2;
                     cmd.interp_go = 1'b1;
                     cmd.xc_sel = bx;
                  end else begin
                     k_in = K_J1;
                     cmd.interp_go = 1'b1;
                     cmd.xc_sel = nb;
                  end
                  st_in = S_WAIT;
               end
               K_J1: begin
                  cmd.emit_cmd  = OP_LINE;
                  cmd.emit_xsel = nb;
                  k_in = K_J2;
                  cmd.interp_go = 1'b1;
                  cmd.xc_sel = bx;
                  st_in = S_WAIT;
               end
               default: begin
                  cmd.emit_cmd  = OP_LINE;
                  cmd.emit_xsel = bx;
                  cmd.emit_last = 1'b1;
                  cmd.upd_out   = 1'b1;
                  cmd.upd_cross = 1'b1;
                  st_in = S_DONE;
               end
            endcase
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         k_ff  <= K_PASS;
      end else begin
         st_ff <= st_in;
         k_ff  <= k_in;
      end
   end
endmodule

[rtl/polyline_x_slab_chopper.sv]
// ----------------------------------------------------------------------------
// polyline_x_slab_chopper
// Clips a stream of move-to/line-to commands to a vertical slab.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one path command per transaction; rsp_* returns zero to
//   three commands for it, the final one flagged by rsp_last_of_run.
//   csr_* writes registers: 0 chop enable, 1 close chops, 2 slab start x,
//   3 slab end x. Write only while the block is idle.
// Timing:
//   One item at a time. Each boundary interpolation runs a partial-product
//   multiply and a bit-serial divide of the 2*COORD_WIDTH+2 bit product;
//   an item needs up to three of them, one after the other.
// Reset:
//   Synchronous, active high; clears registers, path state and the result
//   register.
// Stall:
//   A result waits in the output register; the sequencer holds until it is
//   taken, so no result is lost while rsp_ready is low.
// ----------------------------------------------------------------------------
module polyline_x_slab_chopper
   import pxsc_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [COORD_WIDTH-1:0] req_point_x,
   input  logic [COORD_WIDTH-1:0] req_point_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_command,
   output logic [COORD_WIDTH-1:0] rsp_out_x,
   output logic [COORD_WIDTH-1:0] rsp_out_y,
   output logic                   rsp_last_of_run,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);
   pxsc_cmd_type  cmd;
   pxsc_stat_type stat;
   logic          chop_enable, close_flag;

   assign csr_ready = 1'b1;

   pxsc_control u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .chop_enable (chop_enable),
      .close_flag  (close_flag),
      .stat        (stat),
      .cmd         (cmd)
   );

   pxsc_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .chop_enable     (chop_enable),
      .close_flag      (close_flag),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_command     (rsp_command),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_last_of_run (rsp_last_of_run)
   );
endmodule
